>>> design/spc_pkg.sv
// shared constants for the site percolation block
// no dependencies
package spc_pkg;

    localparam int CFG_W  = 7;
    localparam int SITE_W = 12;
    localparam int SIZE_W = 13;
    localparam int OFF_W  = 8;

    localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

    localparam logic signed [OFF_W-1:0] OFF_MAX = 8'sd127;
    localparam logic signed [OFF_W-1:0] OFF_MIN = -8'sd128;

endpackage

>>> design/site_percolation_union_find_top.sv
// site percolation on a torus with union-find clusters and wrap detection
// depends on spc_pkg and spc_divider
//
// usage: each request on s_ (s_valid/s_ready, s_site_index) gives one result on m_
// (m_percolated, m_cluster_size, m_already_occupied); a free site in range is occupied.
// cfg_valid/cfg_ready/cfg_data writes the lattice side; write it only while idle.
// one request is worked on at a time; s_ready is high only when the sequencer is idle.
// work: four divisions for a fresh site, and for each occupied neighbour the root walk
// and, where the roots differ, one division and a pass over the smaller cluster's members.
// an occupied site takes only its root walk; an out-of-range site skips all work.
// the shared divider and the single read port of the stores set the pace.
// after reset a clearing pass over all MAX_SITES sites empties the occupancy store
// before the first request is taken; configuration writes are taken meanwhile.
// a finished result is held in an output register while the receiver stalls; the
// next request is still taken, but its result waits until that register is free.
module site_percolation_union_find_top
    import spc_pkg::*;
#(
    parameter int MAX_SIDE  = 64,
    parameter int MAX_SITES = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [SITE_W-1:0] s_site_index,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_percolated,
    output logic [SIZE_W-1:0] m_cluster_size,
    output logic              m_already_occupied,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int SW  = $clog2(MAX_SITES);
    localparam int NW  = SW + 1;
    localparam int CW  = NW;
    localparam int DW  = $clog2(MAX_SIDE + 1);
    localparam int DVW = ((NW > DW) ? NW : DW) + 1;

    localparam logic [4:0] ST_CLR   = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_OCC   = 5'd2;
    localparam logic [4:0] ST_INIT  = 5'd3;
    localparam logic [4:0] ST_DIV   = 5'd4;
    localparam logic [4:0] ST_NSEL  = 5'd5;
    localparam logic [4:0] ST_NOCC  = 5'd6;
    localparam logic [4:0] ST_FUP   = 5'd7;
    localparam logic [4:0] ST_FCMP  = 5'd8;
    localparam logic [4:0] ST_R2    = 5'd9;
    localparam logic [4:0] ST_S1    = 5'd10;
    localparam logic [4:0] ST_S2    = 5'd11;
    localparam logic [4:0] ST_W1    = 5'd12;
    localparam logic [4:0] ST_W2    = 5'd13;
    localparam logic [4:0] ST_AK    = 5'd14;
    localparam logic [4:0] ST_AM    = 5'd15;
    localparam logic [4:0] ST_AH    = 5'd16;
    localparam logic [4:0] ST_ALOOP = 5'd17;
    localparam logic [4:0] ST_ATL   = 5'd18;
    localparam logic [4:0] ST_SZ    = 5'd19;
    localparam logic [4:0] ST_DONE  = 5'd20;

    localparam logic FR_OCC = 1'b0;
    localparam logic FR_NB  = 1'b1;

    localparam logic [2:0] DR_XY  = 3'd0;
    localparam logic [2:0] DR_NB2 = 3'd1;
    localparam logic [2:0] DR_SM  = 3'd2;
    localparam logic [2:0] DR_NB3 = 3'd3;
    localparam logic [2:0] DR_A   = 3'd4;

    // stores
    logic                    occ_mem  [MAX_SITES];
    logic [SW-1:0]           par_mem  [MAX_SITES];
    logic [CW-1:0]           sz_mem   [MAX_SITES];
    logic signed [OFF_W-1:0] ox_mem   [MAX_SITES];
    logic signed [OFF_W-1:0] oy_mem   [MAX_SITES];
    logic [SW-1:0]           lab_mem  [MAX_SITES];
    logic [SW-1:0]           nxt_mem  [MAX_SITES];
    logic [SW-1:0]           head_mem [MAX_SITES];
    logic [SW-1:0]           tail_mem [MAX_SITES];

    logic                    occ_q;
    logic [SW-1:0]           par_q, lab_q, nxt_q, head_q, tail_q;
    logic [CW-1:0]           sz_q;
    logic signed [OFF_W-1:0] ox_q, oy_q;

    logic [SW-1:0]           raddr;
    logic                    occ_we, par_we, sz_we, off_we, lab_we, nxt_we, head_we, tail_we;
    logic                    occ_wd;
    logic [SW-1:0]           occ_wa, par_wa, sz_wa, off_wa, lab_wa, nxt_wa, head_wa, tail_wa;
    logic [SW-1:0]           par_wd, lab_wd, nxt_wd, head_wd, tail_wd;
    logic [CW-1:0]           sz_wd;
    logic signed [OFF_W-1:0] ox_wd, oy_wd;

    always_ff @(posedge aclk) begin
        occ_q  <= occ_mem[raddr];
        par_q  <= par_mem[raddr];
        sz_q   <= sz_mem[raddr];
        ox_q   <= ox_mem[raddr];
        oy_q   <= oy_mem[raddr];
        lab_q  <= lab_mem[raddr];
        nxt_q  <= nxt_mem[raddr];
        head_q <= head_mem[raddr];
        tail_q <= tail_mem[raddr];
        if (occ_we) occ_mem[occ_wa] <= occ_wd;
        if (par_we) par_mem[par_wa] <= par_wd;
        if (sz_we) sz_mem[sz_wa] <= sz_wd;
        if (off_we) begin
            ox_mem[off_wa] <= ox_wd;
            oy_mem[off_wa] <= oy_wd;
        end
        if (lab_we) lab_mem[lab_wa] <= lab_wd;
        if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
        if (head_we) head_mem[head_wa] <= head_wd;
        if (tail_we) tail_mem[tail_wa] <= tail_wd;
    end

    // divider
    logic           div_start, div_done;
    logic [DVW-1:0] div_a, div_b, div_quo, div_rem;

    spc_divider #(.W(DVW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // registers
    logic [4:0]              state_reg, state_next;
    logic [CFG_W-1:0]        side_reg, side_next;
    logic [SW-1:0]           clr_reg, clr_next;
    logic [SW-1:0]           site_reg, site_next;
    logic [DW-1:0]           s_reg, s_next;
    logic [NW-1:0]           n_reg, n_next;
    logic [DW-1:0]           x_reg, x_next, y_reg, y_next, ax_reg, ax_next, ay_reg, ay_next;
    logic [SW-1:0]           nb_reg [4];
    logic [SW-1:0]           nb_next [4];
    logic [1:0]              nbi_reg, nbi_next;
    logic [SW-1:0]           a2_reg, a2_next, r1_reg, r1_next, r2_reg, r2_next;
    logic [SW-1:0]           v_reg, v_next, r_reg, r_next;
    logic                    fret_reg, fret_next;
    logic [2:0]              dret_reg, dret_next;
    logic [CW-1:0]           sz1_reg, sz1_next;
    logic [SW-1:0]           keeper_reg, keeper_next, mover_reg, mover_next;
    logic                    ksite_reg, ksite_next;
    logic signed [OFF_W-1:0] okx_reg, okx_next, oky_reg, oky_next;
    logic signed [OFF_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [SW-1:0]           lk_reg, lk_next;
    logic signed [9:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic [SW-1:0]           head_reg, head_next, tailm_reg, tailm_next, m_reg, m_next;
    logic                    wrap_reg, wrap_next;
    logic [CW-1:0]           res_size_reg, res_size_next;
    logic                    res_occ_reg, res_occ_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    o_perc_reg, o_perc_next;
    logic [SIZE_W-1:0]       o_size_reg, o_size_next;
    logic                    o_occ_reg, o_occ_next;

    // combinational helpers
    logic [DW-1:0]           s_c;
    logic [2*DW-1:0]         sq_c;
    logic [NW-1:0]           n_c;
    logic [NW-1:0]           base_c;
    logic [DW:0]             xp1_c;
    logic [DW-1:0]           xp_c, xm_c;
    logic [DW-1:0]           kx_c, ky_c, mx_c, my_c;
    logic signed [DW:0]      ddx_c, ddy_c;
    logic signed [9:0]       dxa_c, dya_c;
    logic signed [10:0]      nx_c, ny_c;
    logic signed [8:0]       wx_c, wy_c;
    logic [CW-1:0]           sum_c;
    logic                    adv, fin;

    function automatic logic signed [1:0] wrap_step(input logic signed [DW:0] d);
        logic signed [1:0] w;
        if (d > $signed((DW+1)'(1))) w = -2'sd1;
        else if (d < -$signed((DW+1)'(1))) w = 2'sd1;
        else w = 2'(d);
        return w;
    endfunction

    function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [10:0] v);
        logic signed [OFF_W-1:0] o;
        if (v > 11'(OFF_MAX)) o = OFF_MAX;
        else if (v < 11'(OFF_MIN)) o = OFF_MIN;
        else o = OFF_W'(v);
        return o;
    endfunction

    function automatic logic in_range(input logic [SW-1:0] p);
        return 32'(p) < MAX_SITES;
    endfunction

    always_comb begin
        if (side_reg < CFG_W'(2)) s_c = DW'(2);
        else if (32'(side_reg) > MAX_SIDE) s_c = DW'(MAX_SIDE);
        else s_c = DW'(side_reg);
        sq_c = (2*DW)'(s_c) * (2*DW)'(s_c);
        n_c  = (32'(sq_c) > MAX_SITES) ? NW'(MAX_SITES) : NW'(sq_c);
    end

    // neighbour columns from the site coordinates
    always_comb begin
        base_c = NW'(site_reg) - NW'(DW'(div_rem));
        xp1_c  = {1'b0, DW'(div_rem)} + 1'b1;
        xp_c   = (xp1_c == {1'b0, s_reg}) ? '0 : DW'(xp1_c);
        xm_c   = (DW'(div_rem) == '0) ? s_reg - 1'b1 : DW'(div_rem) - 1'b1;
    end

    always_comb begin
        kx_c  = ksite_reg ? x_reg : ax_reg;
        ky_c  = ksite_reg ? y_reg : ay_reg;
        mx_c  = ksite_reg ? ax_reg : x_reg;
        my_c  = ksite_reg ? ay_reg : y_reg;
        ddx_c = $signed({1'b0, mx_c}) - $signed({1'b0, kx_c});
        ddy_c = $signed({1'b0, my_c}) - $signed({1'b0, ky_c});
        dxa_c = 10'(okx_reg) - 10'(ox_q) + 10'(wrap_step(ddx_c));
        dya_c = 10'(oky_reg) - 10'(oy_q) + 10'(wrap_step(ddy_c));
        nx_c  = 11'(ox_q) + 11'(dx_reg);
        ny_c  = 11'(oy_q) + 11'(dy_reg);
        wx_c  = 9'(sx_reg) - 9'(ox_q);
        wy_c  = 9'(sy_reg) - 9'(oy_q);
        sum_c = CW'(sz1_reg + sz_q);
    end

    always_comb begin
        state_next    = state_reg;
        side_next     = side_reg;
        clr_next      = clr_reg;
        site_next     = site_reg;
        s_next        = s_reg;
        n_next        = n_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        nb_next       = nb_reg;
        nbi_next      = nbi_reg;
        a2_next       = a2_reg;
        r1_next       = r1_reg;
        r2_next       = r2_reg;
        v_next        = v_reg;
        r_next        = r_reg;
        fret_next     = fret_reg;
        dret_next     = dret_reg;
        sz1_next      = sz1_reg;
        keeper_next   = keeper_reg;
        mover_next    = mover_reg;
        ksite_next    = ksite_reg;
        okx_next      = okx_reg;
        oky_next      = oky_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        lk_next       = lk_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        head_next     = head_reg;
        tailm_next    = tailm_reg;
        m_next        = m_reg;
        wrap_next     = wrap_reg;
        res_size_next = res_size_reg;
        res_occ_next  = res_occ_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        o_perc_next   = o_perc_reg;
        o_size_next   = o_size_reg;
        o_occ_next    = o_occ_reg;

        raddr     = site_reg;
        div_start = 1'b0;
        div_a     = DVW'(site_reg);
        div_b     = DVW'(s_reg);
        occ_we = 1'b0; occ_wa = site_reg; occ_wd = 1'b1;
        par_we = 1'b0; par_wa = site_reg; par_wd = site_reg;
        sz_we  = 1'b0; sz_wa  = site_reg; sz_wd  = CW'(1);
        off_we = 1'b0; off_wa = site_reg; ox_wd = '0; oy_wd = '0;
        lab_we = 1'b0; lab_wa = site_reg; lab_wd = site_reg;
        nxt_we = 1'b0; nxt_wa = tail_q;   nxt_wd = head_reg;
        head_we = 1'b0; head_wa = site_reg; head_wd = site_reg;
        tail_we = 1'b0; tail_wa = site_reg; tail_wd = site_reg;
        adv = 1'b0;
        fin = 1'b0;

        if (cfg_valid) side_next = cfg_data;

        unique case (state_reg)
            ST_CLR: begin
                occ_we = 1'b1;
                occ_wa = clr_reg;
                occ_wd = 1'b0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(MAX_SITES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    site_next = SW'(s_site_index);
                    s_next    = s_c;
                    n_next    = n_c;
                    if (32'(s_site_index) >= 32'(n_c)) begin
                        res_size_next = '0;
                        res_occ_next  = 1'b0;
                        state_next    = ST_DONE;
                    end else begin
                        raddr      = SW'(s_site_index);
                        state_next = ST_OCC;
                    end
                end
            end
            ST_OCC: begin
                if (occ_q) begin
                    res_occ_next = 1'b1;
                    v_next       = site_reg;
                    r_next       = site_reg;
                    fret_next    = FR_OCC;
                    raddr        = site_reg;
                    state_next   = ST_FUP;
                end else begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                occ_we = 1'b1; par_we = 1'b1; sz_we = 1'b1; off_we = 1'b1;
                lab_we = 1'b1; head_we = 1'b1; tail_we = 1'b1;
                res_occ_next = 1'b0;
                r1_next      = site_reg;
                div_start    = 1'b1;
                dret_next    = DR_XY;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    case (dret_reg)
                        DR_XY: begin
                            x_next     = DW'(div_rem);
                            y_next     = DW'(div_quo);
                            nb_next[0] = SW'(base_c + NW'(xp_c));
                            nb_next[1] = SW'(base_c + NW'(xm_c));
                            div_start  = 1'b1;
                            div_a      = DVW'(site_reg) + DVW'(s_reg);
                            div_b      = DVW'(n_reg);
                            dret_next  = DR_NB2;
                        end
                        DR_NB2: begin
                            nb_next[2] = SW'(div_rem);
                            div_start  = 1'b1;
                            div_a      = DVW'(s_reg);
                            div_b      = DVW'(n_reg);
                            dret_next  = DR_SM;
                        end
                        DR_SM: begin
                            div_start = 1'b1;
                            div_a     = DVW'(site_reg) + DVW'(n_reg) - div_rem;
                            div_b     = DVW'(n_reg);
                            dret_next = DR_NB3;
                        end
                        DR_NB3: begin
                            nb_next[3] = SW'(div_rem);
                            nbi_next   = '0;
                            state_next = ST_NSEL;
                        end
                        default: begin
                            ax_next    = DW'(div_rem);
                            ay_next    = DW'(div_quo);
                            raddr      = keeper_reg;
                            state_next = ST_AK;
                        end
                    endcase
                end
            end
            ST_NSEL: begin
                a2_next    = nb_reg[nbi_reg];
                raddr      = nb_reg[nbi_reg];
                state_next = ST_NOCC;
            end
            ST_NOCC: begin
                if (!occ_q) begin
                    adv = 1'b1;
                end else begin
                    v_next     = a2_reg;
                    r_next     = a2_reg;
                    fret_next  = FR_NB;
                    raddr      = a2_reg;
                    state_next = ST_FUP;
                end
            end
            ST_FUP: begin
                if (par_q == r_reg || !in_range(par_q)) begin
                    if (v_reg == r_reg) begin
                        fin = 1'b1;
                    end else begin
                        raddr      = v_reg;
                        state_next = ST_FCMP;
                    end
                end else begin
                    r_next = par_q;
                    raddr  = par_q;
                end
            end
            ST_FCMP: begin
                // path compression: point each visited node at the root
                par_we = 1'b1;
                par_wa = v_reg;
                par_wd = r_reg;
                v_next = par_q;
                if (!in_range(par_q) || par_q == r_reg) fin = 1'b1;
                else raddr = par_q;
            end
            ST_R2: begin
                if (r2_reg != r1_reg) begin
                    raddr      = r1_reg;
                    state_next = ST_S1;
                end else begin
                    raddr      = site_reg;
                    state_next = ST_W1;
                end
            end
            ST_S1: begin
                sz1_next   = sz_q;
                raddr      = r2_reg;
                state_next = ST_S2;
            end
            ST_S2: begin
                par_we = 1'b1;
                sz_we  = 1'b1;
                sz_wd  = sum_c;
                if (sz1_reg > sz_q) begin
                    par_wa      = r2_reg;
                    par_wd      = r1_reg;
                    sz_wa       = r1_reg;
                    keeper_next = site_reg;
                    mover_next  = a2_reg;
                    ksite_next  = 1'b1;
                end else begin
                    // tie goes to the neighbour's cluster
                    par_wa      = r1_reg;
                    par_wd      = r2_reg;
                    sz_wa       = r2_reg;
                    keeper_next = a2_reg;
                    mover_next  = site_reg;
                    ksite_next  = 1'b0;
                    r1_next     = r2_reg;
                end
                div_start  = 1'b1;
                div_a      = DVW'(a2_reg);
                div_b      = DVW'(s_reg);
                dret_next  = DR_A;
                state_next = ST_DIV;
            end
            ST_W1: begin
                sx_next    = ox_q;
                sy_next    = oy_q;
                raddr      = a2_reg;
                state_next = ST_W2;
            end
            ST_W2: begin
                if (wx_c > 9'sd1 || wx_c < -9'sd1 || wy_c > 9'sd1 || wy_c < -9'sd1)
                    wrap_next = 1'b1;
                adv = 1'b1;
            end
            ST_AK: begin
                okx_next   = ox_q;
                oky_next   = oy_q;
                lk_next    = lab_q;
                raddr      = mover_reg;
                state_next = ST_AM;
            end
            ST_AM: begin
                dx_next = dxa_c;
                dy_next = dya_c;
                if (lk_reg == lab_q || !in_range(lk_reg) || !in_range(lab_q)) begin
                    adv = 1'b1;
                end else begin
                    raddr      = lab_q;
                    state_next = ST_AH;
                end
            end
            ST_AH: begin
                head_next  = head_q;
                tailm_next = tail_q;
                m_next     = head_q;
                raddr      = head_q;
                state_next = ST_ALOOP;
            end
            ST_ALOOP: begin
                // walk the mover's member list, shifting and relabelling
                off_we = 1'b1;
                off_wa = m_reg;
                ox_wd  = sat_off(nx_c);
                oy_wd  = sat_off(ny_c);
                lab_we = 1'b1;
                lab_wa = m_reg;
                lab_wd = lk_reg;
                if (m_reg == tailm_reg) begin
                    raddr      = lk_reg;
                    state_next = ST_ATL;
                end else begin
                    m_next = nxt_q;
                    raddr  = nxt_q;
                end
            end
            ST_ATL: begin
                nxt_we  = in_range(tail_q);
                tail_we = 1'b1;
                tail_wa = lk_reg;
                tail_wd = tailm_reg;
                adv     = 1'b1;
            end
            ST_SZ: begin
                res_size_next = sz_q;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_perc_next  = wrap_reg;
                    o_size_next  = SIZE_W'(res_size_reg);
                    o_occ_next   = res_occ_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (fin) begin
            if (fret_reg == FR_OCC) begin
                raddr      = r_reg;
                state_next = ST_SZ;
            end else begin
                r2_next    = r_reg;
                state_next = ST_R2;
            end
        end

        if (adv) begin
            if (nbi_reg == 2'd3) begin
                raddr      = r1_reg;
                state_next = ST_SZ;
            end else begin
                nbi_next   = nbi_reg + 1'b1;
                state_next = ST_NSEL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_reg     <= '0;
            side_reg    <= SIDE_RESET;
            wrap_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            side_reg    <= side_next;
            wrap_reg    <= wrap_next;
            m_valid_reg <= m_valid_next;
        end
        site_reg     <= site_next;
        s_reg        <= s_next;
        n_reg        <= n_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        nb_reg       <= nb_next;
        nbi_reg      <= nbi_next;
        a2_reg       <= a2_next;
        r1_reg       <= r1_next;
        r2_reg       <= r2_next;
        v_reg        <= v_next;
        r_reg        <= r_next;
        fret_reg     <= fret_next;
        dret_reg     <= dret_next;
        sz1_reg      <= sz1_next;
        keeper_reg   <= keeper_next;
        mover_reg    <= mover_next;
        ksite_reg    <= ksite_next;
        okx_reg      <= okx_next;
        oky_reg      <= oky_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        lk_reg       <= lk_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        head_reg     <= head_next;
        tailm_reg    <= tailm_next;
        m_reg        <= m_next;
        res_size_reg <= res_size_next;
        res_occ_reg  <= res_occ_next;
        o_perc_reg   <= o_perc_next;
        o_size_reg   <= o_size_next;
        o_occ_reg    <= o_occ_next;
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign cfg_ready          = 1'b1;
    assign m_valid            = m_valid_reg;
    assign m_percolated       = o_perc_reg;
    assign m_cluster_size     = o_size_reg;
    assign m_already_occupied = o_occ_reg;

endmodule

>>> design/spc_divider.sv
// restoring divider, one quotient bit per cycle
// no dependencies; used by site_percolation_union_find_top
module spc_divider #(
    parameter int W = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
